[src/fu_pkg.sv]
// Shared types, constants and the bicubic coefficient function of the field upscaler.
// Depends on nothing; every other file refers to it by scoped names.
package fu_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int MAX_SRC_DIM = 128;
	localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DIV_W       = 28;
	localparam int DSR_W       = 12;
	localparam int FRAC_W      = 16;
	localparam int ACC_W       = 48;
	localparam int PROD_W      = 64;
	localparam int COEF_W      = 34;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef sample_t win_t [3][3];
	typedef logic signed [COEF_W-1:0] coef_t;

	function automatic coef_t ext(input sample_t v);
		return {{(COEF_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

	// Coefficient a[i][j] of the bicubic patch, built from forward differences.
	function automatic coef_t coef(input win_t s, input logic [1:0] i, input logic [1:0] j);
		coef_t f00, f10, f01, f11;
		coef_t dx00, dx10, dx01, dx11, dy00, dy10, dy01, dy11;
		coef_t dxy00, dxy10, dxy01, dxy11;
		coef_t r;
		f00 = ext(s[0][0]);
		f10 = ext(s[0][1]);
		f01 = ext(s[1][0]);
		f11 = ext(s[1][1]);
		dx00 = ext(s[0][1]) - ext(s[0][0]);
		dx10 = ext(s[0][2]) - ext(s[0][1]);
		dx01 = ext(s[1][1]) - ext(s[1][0]);
		dx11 = ext(s[1][2]) - ext(s[1][1]);
		dy00 = ext(s[1][0]) - ext(s[0][0]);
		dy10 = ext(s[1][1]) - ext(s[0][1]);
		dy01 = ext(s[2][0]) - ext(s[1][0]);
		dy11 = ext(s[2][1]) - ext(s[1][1]);
		dxy00 = dy10 - dy00;
		dxy10 = (ext(s[1][2]) - ext(s[0][2])) - dy10;
		dxy01 = dy11 - dy01;
		dxy11 = (ext(s[2][2]) - ext(s[1][2])) - dy11;
		case ({i, j})
			4'h0: r = f00;
			4'h1: r = dy00;
			4'h2: r = -3*f00 + 3*f01 - 2*dy00 - dy01;
			4'h3: r = 2*f00 - 2*f01 + dy00 + dy01;
			4'h4: r = dx00;
			4'h5: r = dxy00;
			4'h6: r = -3*dx00 + 3*dx01 - 2*dxy00 - dxy01;
			4'h7: r = 2*dx00 - 2*dx01 + dxy00 + dxy01;
			4'h8: r = -3*f00 + 3*f10 - 2*dx00 - dx10;
			4'h9: r = -2*dxy00 - dxy10 - 3*dy00 + 3*dy10;
			4'hA: r = 9*f00 - 9*f01 - 9*f10 + 9*f11 + 6*dx00 - 6*dx01 + 3*dx10 - 3*dx11
				+ 4*dxy00 + 2*dxy01 + 2*dxy10 + dxy11 + 6*dy00 + 3*dy01 - 6*dy10 - 3*dy11;
			4'hB: r = -6*f00 + 6*f01 + 6*f10 - 6*f11 - 4*dx00 + 4*dx01 - 2*dx10 + 2*dx11
				- 2*dxy00 - 2*dxy01 - dxy10 - dxy11 - 3*dy00 - 3*dy01 + 3*dy10 + 3*dy11;
			4'hC: r = 2*f00 - 2*f10 + dx00 + dx10;
			4'hD: r = dxy00 + dxy10 + 2*dy00 - 2*dy10;
			4'hE: r = -6*f00 + 6*f01 + 6*f10 - 6*f11 - 3*dx00 + 3*dx01 - 3*dx10 + 3*dx11
				- 2*dxy00 - dxy01 - 2*dxy10 - dxy11 - 4*dy00 - 2*dy01 + 4*dy10 + 2*dy11;
			default: r = 4*f00 - 4*f01 - 4*f10 + 4*f11 + 2*dx00 - 2*dx01 + 2*dx10 - 2*dx11
				+ dxy00 + dxy01 + dxy10 + dxy11 + 2*dy00 + 2*dy01 - 2*dy10 - 2*dy11;
		endcase
		return r;
	endfunction

endpackage

[src/field_upscaler_bilinear_bicubic_unit.sv]
// Integer-factor field upscaler, bilinear or bicubic, over a 128 x 128 sample store.
// Depends on fu_pkg, fu_ram, fu_div and fu_mul.
// A write transfer does not occupy the unit and a new transfer may follow at once. A query
// holds the unit busy: two 28-step dividers run twice (scale, then position), the single
// store port gives one sample per cycle (4 or 9), and the shared two-stage multiplier takes
// each product through S_MUL, S_W1 and S_USE (3 or 15 products).
// Reset sets the configuration and control registers to their defaults; the store is not cleared.
module field_upscaler_bilinear_bicubic_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [2:0]                  cfg_index,
	input  logic [12:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [13:0]                 sample_index,
	input  logic signed [23:0]          sample_value,
	input  logic [11:0]                 out_x,
	input  logic [11:0]                 out_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [31:0]          pixel_value,
	output logic [1:0]                  status
);

	localparam logic [2:0] CFG_SRC_W = 3'd0;
	localparam logic [2:0] CFG_SRC_H = 3'd1;
	localparam logic [2:0] CFG_DST_W = 3'd2;
	localparam logic [2:0] CFG_DST_H = 3'd3;
	localparam logic [2:0] CFG_MODE  = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_POS, S_READ, S_LAST, S_INIT, S_MUL, S_W1, S_USE, S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0]  sw_q, sh_q;
	logic [12:0] tw_q, th_q;
	logic        mode_q;

	// Query working registers.
	logic [11:0] ox_q, oy_q;
	logic [7:0]  x_q, y_q;
	logic [15:0] fx_q, fy_q;
	logic [1:0]  ri_q, rj_q, cap_i_q, cap_j_q;
	logic        cap_q;
	fu_pkg::win_t s_q;
	logic [1:0]  ci_q, cj_q, step_q;
	logic        xph_q;
	logic signed [fu_pkg::ACC_W-1:0] v_q, row0_q, row1_q;
	logic signed [fu_pkg::ACC_W-1:0] p_q [4];
	logic signed [31:0] res_q;
	logic [1:0]  st_q;
	logic        out_valid_q;
	logic signed [31:0] pix_q;
	logic [1:0]  stat_q;

	// Divider connections.
	logic        go_q;
	logic [fu_pkg::DIV_W-1:0] dvd_x_q, dvd_y_q, qx, qy;
	logic [fu_pkg::DSR_W-1:0] dsr_x_q, dsr_y_q;
	logic        dx_done, dy_done;

	// Store and multiplier connections.
	logic        ram_we;
	logic [fu_pkg::ADDR_W-1:0] ram_addr, rd_addr;
	fu_pkg::sample_t ram_rdata;
	logic [8:0]  rrow, rcol;
	logic [16:0] rowmul, addr_sum;
	logic signed [fu_pkg::ACC_W-1:0] mul_a;
	logic [15:0] mul_b;
	logic signed [fu_pkg::PROD_W-1:0] prod;

	logic [7:0]  need, lim_x, lim_y;
	logic [1:0]  last_idx;
	logic [1:0]  cj_sel;
	fu_pkg::coef_t cf;
	logic signed [fu_pkg::ACC_W-1:0] cf_sh, prod_sh, vn, xn;
	logic signed [24:0] dtop, dbot;
	logic signed [fu_pkg::PROD_W-1:0] rn;
	logic signed [39:0] rounded;
	logic        accept;
	logic        load_out;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign pixel_value = pix_q;
	assign status    = stat_q;

	// A finished result moves into the output register once that register is free.
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign need     = mode_q ? 8'd3 : 8'd2;
	assign lim_x    = sw_q - need;
	assign lim_y    = sh_q - need;
	assign last_idx = mode_q ? 2'd2 : 2'd1;

	// Store address of the window sample at row ri, column rj; it wraps at the store depth.
	assign rrow     = {1'b0, y_q} + {7'b0, ri_q};
	assign rcol     = {1'b0, x_q} + {7'b0, rj_q};
	assign rowmul   = rrow * sw_q;
	assign addr_sum = rowmul + {8'b0, rcol};
	assign rd_addr  = addr_sum[fu_pkg::ADDR_W-1:0];

	assign ram_we   = accept && (opcode == fu_pkg::OP_WRITE);
	assign ram_addr = ram_we ? sample_index : rd_addr;

	fu_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (sample_value),
		.rdata (ram_rdata)
	);

	fu_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend (dvd_x_q),
		.divisor  (dsr_x_q),
		.done     (dx_done),
		.quotient (qx)
	);

	fu_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_q),
		.dividend (dvd_y_q),
		.divisor  (dsr_y_q),
		.done     (dy_done),
		.quotient (qy)
	);

	// Multiplier operands: bilinear mixes sample differences by the fractions, bicubic
	// runs Horner's rule on the running value.
	assign dtop = $signed({s_q[0][1][23], s_q[0][1]}) - $signed({s_q[0][0][23], s_q[0][0]});
	assign dbot = $signed({s_q[1][1][23], s_q[1][1]}) - $signed({s_q[1][0][23], s_q[1][0]});

	always_comb begin
		if (mode_q) begin
			mul_a = v_q;
			mul_b = xph_q ? fx_q : fy_q;
		end else begin
			case (step_q)
				2'd0:    mul_a = {{(fu_pkg::ACC_W-25){dtop[24]}}, dtop};
				2'd1:    mul_a = {{(fu_pkg::ACC_W-25){dbot[24]}}, dbot};
				default: mul_a = row1_q - row0_q;
			endcase
			mul_b = (step_q == 2'd2) ? fy_q : fx_q;
		end
	end

	fu_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// One coefficient at a time; the row start takes the cubic term.
	assign cj_sel  = (state_q == S_INIT) ? 2'd3 : cj_q;
	assign cf      = fu_pkg::coef(s_q, ci_q, cj_sel);
	assign cf_sh   = {{(fu_pkg::ACC_W-fu_pkg::COEF_W-8){cf[fu_pkg::COEF_W-1]}}, cf, 8'b0};
	assign prod_sh = prod[fu_pkg::ACC_W+15:16];
	assign vn      = cf_sh + prod_sh;
	assign xn      = p_q[ci_q] + prod_sh;
	assign rounded = 40'((xn + 48'sd128) >>> 8);
	assign rn      = {row0_q[fu_pkg::ACC_W-1:0], 16'b0} + prod + 64'sh8000_0000;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -40'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= 8'd128;
			sh_q   <= 8'd128;
			tw_q   <= 13'd512;
			th_q   <= 13'd512;
			mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_SRC_W: sw_q   <= cfg_data[7:0];
				CFG_SRC_H: sh_q   <= cfg_data[7:0];
				CFG_DST_W: tw_q   <= cfg_data;
				CFG_DST_H: th_q   <= cfg_data;
				CFG_MODE:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Window capture: the registered store read answers in the cycle after each read address.
	always_ff @(posedge clk) begin
		if (cap_q) begin
			s_q[cap_i_q][cap_j_q] <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			cap_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The dividers start on an accepted query that passes the size check, and
			// again once a nonzero scale is known.
			go_q  <= (state_q == S_IDLE && accept && opcode == fu_pkg::OP_QUERY
					&& sw_q >= need && sh_q >= need)
				|| (state_q == S_SCALE && dx_done && dy_done
					&& qx[11:0] != 12'd0 && qy[11:0] != 12'd0);
			cap_q <= (state_q == S_READ);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == fu_pkg::OP_QUERY) begin
						ox_q <= out_x;
						oy_q <= out_y;
						if (sw_q < need || sh_q < need) begin
							res_q   <= '0;
							st_q    <= fu_pkg::ST_SMALL;
							state_q <= S_DONE;
						end else begin
							dvd_x_q <= {15'b0, tw_q};
							dvd_y_q <= {15'b0, th_q};
							dsr_x_q <= {4'b0, sw_q};
							dsr_y_q <= {4'b0, sh_q};
							state_q <= S_SCALE;
						end
					end
				end
				S_SCALE: begin
					if (dx_done && dy_done) begin
						if (qx[11:0] == 12'd0 || qy[11:0] == 12'd0) begin
							res_q   <= '0;
							st_q    <= fu_pkg::ST_ZERO;
							state_q <= S_DONE;
						end else begin
							// Quotient of coord*65536 by scale: integer part over fraction.
							dvd_x_q <= {ox_q, 16'b0};
							dvd_y_q <= {oy_q, 16'b0};
							dsr_x_q <= qx[11:0];
							dsr_y_q <= qy[11:0];
							state_q <= S_POS;
						end
					end
				end
				S_POS: begin
					if (dx_done && dy_done) begin
						fx_q    <= qx[15:0];
						fy_q    <= qy[15:0];
						x_q     <= (qx[27:16] > {4'b0, lim_x}) ? lim_x : qx[23:16];
						y_q     <= (qy[27:16] > {4'b0, lim_y}) ? lim_y : qy[23:16];
						ri_q    <= '0;
						rj_q    <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					cap_i_q <= ri_q;
					cap_j_q <= rj_q;
					if (rj_q == last_idx) begin
						rj_q <= '0;
						if (ri_q == last_idx) begin
							state_q <= S_LAST;
						end else begin
							ri_q <= ri_q + 1'b1;
						end
					end else begin
						rj_q <= rj_q + 1'b1;
					end
				end
				S_LAST: begin
					ci_q    <= '0;
					xph_q   <= 1'b0;
					step_q  <= '0;
					state_q <= mode_q ? S_INIT : S_MUL;
				end
				S_INIT: begin
					v_q     <= cf_sh;
					cj_q    <= 2'd2;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_W1;
				end
				S_W1: begin
					state_q <= S_USE;
				end
				S_USE: begin
					if (!mode_q) begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
						// Each row is kept exact in Q.16: sample times 65536 plus the
						// full product of the difference and the fraction.
						case (step_q)
							2'd0: row0_q <= {{8{s_q[0][0][23]}}, s_q[0][0], 16'b0}
								+ prod[fu_pkg::ACC_W-1:0];
							2'd1: row1_q <= {{8{s_q[1][0][23]}}, s_q[1][0], 16'b0}
								+ prod[fu_pkg::ACC_W-1:0];
							default: begin
								res_q   <= rn[63:32];
								st_q    <= fu_pkg::ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end else if (!xph_q) begin
						if (cj_q == 2'd0) begin
							p_q[ci_q] <= vn;
							if (ci_q == 2'd3) begin
								xph_q   <= 1'b1;
								ci_q    <= 2'd2;
								v_q     <= vn;
								state_q <= S_MUL;
							end else begin
								ci_q    <= ci_q + 1'b1;
								state_q <= S_INIT;
							end
						end else begin
							v_q     <= vn;
							cj_q    <= cj_q - 1'b1;
							state_q <= S_MUL;
						end
					end else begin
						if (ci_q == 2'd0) begin
							res_q   <= sat32(rounded);
							st_q    <= fu_pkg::ST_OK;
							state_q <= S_DONE;
						end else begin
							v_q     <= xn;
							ci_q    <= ci_q - 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					// The result waits here until the output register is free.
					if (load_out) begin
						pix_q   <= res_q;
						stat_q  <= st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/fu_ram.sv]
// Single-port source sample store with a registered read port.
// Depends on fu_pkg for depth and sample width.
module fu_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [fu_pkg::ADDR_W-1:0] addr,
	input  fu_pkg::sample_t           wdata,
	output fu_pkg::sample_t           rdata
);

	fu_pkg::sample_t mem [fu_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

[src/fu_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on fu_pkg for operand widths.
module fu_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [fu_pkg::DIV_W-1:0] dividend,
	input  logic [fu_pkg::DSR_W-1:0] divisor,
	output logic                     done,
	output logic [fu_pkg::DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(fu_pkg::DIV_W);

	logic [fu_pkg::DIV_W-1:0] quo_q;
	logic [fu_pkg::DSR_W-1:0] rem_q;
	logic [fu_pkg::DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [fu_pkg::DSR_W:0]   trial;
	logic                     fits;
	logic                     last_step;

	assign trial     = {rem_q, quo_q[fu_pkg::DIV_W-1]};
	assign fits      = trial >= {1'b0, dsr_q};
	assign last_step = busy_q && (cnt_q == CNT_W'(fu_pkg::DIV_W - 1));
	assign done      = done_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? fu_pkg::DSR_W'(trial - {1'b0, dsr_q}) : trial[fu_pkg::DSR_W-1:0];
			quo_q <= {quo_q[fu_pkg::DIV_W-2:0], fits};
		end
	end

endmodule

[src/fu_mul.sv]
// Two-stage signed-by-fraction multiplier: the wide operand is split in two halves.
// Depends on fu_pkg for operand and product widths.
module fu_mul (
	input  logic                             clk,
	input  logic signed [fu_pkg::ACC_W-1:0]  a,
	input  logic [fu_pkg::FRAC_W-1:0]        b,
	output logic signed [fu_pkg::PROD_W-1:0] prod
);

	localparam int HALF = fu_pkg::ACC_W / 2;

	logic signed [HALF+fu_pkg::FRAC_W:0] hi_s1;
	logic [HALF+fu_pkg::FRAC_W-1:0]      lo_s1;
	logic signed [fu_pkg::PROD_W-1:0]    hi_ext;

	assign hi_ext = {{(fu_pkg::PROD_W-HALF-fu_pkg::FRAC_W-1){hi_s1[HALF+fu_pkg::FRAC_W]}}, hi_s1};

	always_ff @(posedge clk) begin
		hi_s1 <= $signed(a[fu_pkg::ACC_W-1:HALF]) * $signed({1'b0, b});
		lo_s1 <= a[HALF-1:0] * b;
		prod  <= (hi_ext <<< HALF)
			+ $signed({{(fu_pkg::PROD_W-HALF-fu_pkg::FRAC_W){1'b0}}, lo_s1});
	end

endmodule

[src/fu_checker.sv]
// Port-level checks for the field upscaler, attached to the top level by bind.
// Depends on fu_pkg for the status codes and opcodes.
module fu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               opcode,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pixel_value,
	input logic [1:0]         status
);

	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(status))
		else $error("stalled result changed");

	ap_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fu_pkg::ST_OK |-> pixel_value == 32'sd0)
		else $error("error status with nonzero value");

	ap_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == fu_pkg::OP_QUERY |=> in_stall)
		else $error("query transfer did not occupy the unit");

	ap_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a query in progress");

endmodule

bind field_upscaler_bilinear_bicubic_unit fu_checker u_fu_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_value (pixel_value),
	.status      (status)
);

[test/tb_top.sv]
// Self-checking testbench for the field upscaler: directed table, then random phases.
// Depends on fu_pkg and field_upscaler_bilinear_bicubic_unit; carries its own interpolation model.
module tb_top;

	// Register indexes of the configuration port, in the order the block defines them.
	typedef enum logic [2:0] {
		REG_SRC_W = 3'd0,
		REG_SRC_H = 3'd1,
		REG_DST_W = 3'd2,
		REG_DST_H = 3'd3,
		REG_MODE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {ROW_WR, ROW_QY, ROW_CFG} row_kind_t;

	// One row of the directed table. For configuration rows idx is the register and
	// val the data. A typed expectation is used only where has_exp is set.
	typedef struct {
		row_kind_t     kind;
		int unsigned   idx;
		int            val;
		int unsigned   ox;
		int unsigned   oy;
		bit            has_exp;
		int            exp_pix;
		logic [1:0]    exp_st;
	} dir_row_t;

	typedef struct {
		logic signed [31:0] pix;
		logic [1:0]         st;
	} pixel_res_t;

	localparam int SETTLE   = 200;
	localparam int LIMIT    = 1000000;
	localparam int N_ITEMS  = 650;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [2:0]         cfg_index;
	logic [12:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               opcode;
	logic [13:0]        sample_index;
	logic signed [23:0] sample_value;
	logic [11:0]        out_x;
	logic [11:0]        out_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] pixel_value;
	logic [1:0]         status;

	field_upscaler_bilinear_bicubic_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .sample_index(sample_index), .sample_value(sample_value),
		.out_x(out_x), .out_y(out_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_value(pixel_value), .status(status)
	);

	// Our own copy of the block's state: the sample store, which entries have been
	// written since reset, and the configuration.
	logic signed [23:0] field_mem [fu_pkg::STORE_DEPTH];
	bit                 field_set [fu_pkg::STORE_DEPTH];
	int unsigned        src_w, src_h, dst_w, dst_h, mode_cubic;

	pixel_res_t  pending_pixels [$];
	int          n_errors;
	int          n_sent;
	longint      cyc;
	int          hold_left;
	bit          hold_done;

	// Quiet window: neither side idles, so back-to-back transfers are seen.
	function automatic bit quiet();
		return cyc >= 15000 && cyc < 25000;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle counter and overall time limit.
	initial begin
		cyc = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc > LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Interpolation model
	// ------------------------------------------------------------------
	function automatic longint tap(int unsigned c, int unsigned r);
		int unsigned a;
		a = (c + r * src_w) % fu_pkg::STORE_DEPTH;
		return longint'(field_mem[a]);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Works out the neighbourhood origin and fractions; st tells whether the query
	// reads the store at all.
	function automatic void locate(input int unsigned ox, input int unsigned oy,
			output logic [1:0] st, output int unsigned bx, output int unsigned by,
			output longint fx, output longint fy);
		int unsigned need, sx, sy;
		need = mode_cubic ? 3 : 2;
		bx = 0;
		by = 0;
		fx = 0;
		fy = 0;
		if (src_w < need || src_h < need) begin
			st = fu_pkg::ST_SMALL;
		end else begin
			sx = (dst_w / src_w) & 12'hFFF;
			sy = (dst_h / src_h) & 12'hFFF;
			if (sx == 0 || sy == 0) begin
				st = fu_pkg::ST_ZERO;
			end else begin
				st = fu_pkg::ST_OK;
				bx = ox / sx;
				by = oy / sy;
				fx = ((longint'(ox % sx)) << 16) / sx;
				fy = ((longint'(oy % sy)) << 16) / sy;
				if (bx > src_w - need)
					bx = src_w - need;
				if (by > src_h - need)
					by = src_h - need;
			end
		end
	endfunction

	function automatic pixel_res_t interpolate(int unsigned ox, int unsigned oy);
		pixel_res_t res;
		logic [1:0] st;
		int unsigned x, y;
		longint fx, fy, row0, row1, acc, v;
		longint s [3][3];
		longint a [4][4];
		longint p [4];
		longint f00, f10, f01, f11, dx00, dx10, dx01, dx11, dy00, dy10, dy01, dy11;
		longint dxy00, dxy10, dxy01, dxy11;
		locate(ox, oy, st, x, y, fx, fy);
		res.st = st;
		res.pix = 0;
		if (st != fu_pkg::ST_OK)
			return res;
		if (!mode_cubic) begin
			row0 = (65536 - fx) * tap(x, y) + fx * tap(x + 1, y);
			row1 = (65536 - fx) * tap(x, y + 1) + fx * tap(x + 1, y + 1);
			acc = row0 * (65536 - fy) + row1 * fy;
			res.pix = 32'(sat32((acc + (64'sd1 << 31)) >>> 32));
			return res;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				s[i][j] = tap(x + j, y + i);
		f00 = s[0][0]; f10 = s[0][1]; f01 = s[1][0]; f11 = s[1][1];
		dx00 = s[0][1] - s[0][0]; dx10 = s[0][2] - s[0][1];
		dx01 = s[1][1] - s[1][0]; dx11 = s[1][2] - s[1][1];
		dy00 = s[1][0] - s[0][0]; dy10 = s[1][1] - s[0][1];
		dy01 = s[2][0] - s[1][0]; dy11 = s[2][1] - s[1][1];
		dxy00 = dy10 - dy00;
		dxy10 = (s[1][2] - s[0][2]) - dy10;
		dxy01 = dy11 - dy01;
		dxy11 = (s[2][2] - s[1][2]) - dy11;
		a[0][0] = f00;
		a[1][0] = dx00;
		a[0][1] = dy00;
		a[1][1] = dxy00;
		a[2][0] = -3*f00 + 3*f10 - 2*dx00 - dx10;
		a[0][2] = -3*f00 + 3*f01 - 2*dy00 - dy01;
		a[2][1] = -2*dxy00 - dxy10 - 3*dy00 + 3*dy10;
		a[1][2] = -3*dx00 + 3*dx01 - 2*dxy00 - dxy01;
		a[2][2] = 9*f00 - 9*f01 - 9*f10 + 9*f11 + 6*dx00 - 6*dx01 + 3*dx10 - 3*dx11
			+ 4*dxy00 + 2*dxy01 + 2*dxy10 + dxy11 + 6*dy00 + 3*dy01 - 6*dy10 - 3*dy11;
		a[3][0] = 2*f00 - 2*f10 + dx00 + dx10;
		a[0][3] = 2*f00 - 2*f01 + dy00 + dy01;
		a[3][1] = dxy00 + dxy10 + 2*dy00 - 2*dy10;
		a[1][3] = 2*dx00 - 2*dx01 + dxy00 + dxy01;
		a[2][3] = -6*f00 + 6*f01 + 6*f10 - 6*f11 - 4*dx00 + 4*dx01 - 2*dx10 + 2*dx11
			- 2*dxy00 - 2*dxy01 - dxy10 - dxy11 - 3*dy00 - 3*dy01 + 3*dy10 + 3*dy11;
		a[3][2] = -6*f00 + 6*f01 + 6*f10 - 6*f11 - 3*dx00 + 3*dx01 - 3*dx10 + 3*dx11
			- 2*dxy00 - dxy01 - 2*dxy10 - dxy11 - 4*dy00 - 2*dy01 + 4*dy10 + 2*dy11;
		a[3][3] = 4*f00 - 4*f01 - 4*f10 + 4*f11 + 2*dx00 - 2*dx01 + 2*dx10 - 2*dx11
			+ dxy00 + dxy01 + dxy10 + dxy11 + 2*dy00 + 2*dy01 - 2*dy10 - 2*dy11;
		// Horner in y for each column power of x, coefficients moved to Q.8.
		for (int i = 0; i < 4; i++) begin
			v = a[i][3] * 256;
			for (int j = 2; j >= 0; j--)
				v = a[i][j] * 256 + ((v * fy) >>> 16);
			p[i] = v;
		end
		v = p[3];
		for (int i = 2; i >= 0; i--)
			v = p[i] + ((v * fx) >>> 16);
		res.pix = 32'(sat32((v + 128) >>> 8));
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	// Offers one transfer, idling first at random, and returns once it is accepted.
	task automatic offer(input logic op, input logic [13:0] idx, input logic [23:0] val,
			input logic [11:0] ox, input logic [11:0] oy);
		int gap;
		gap = 0;
		if (!quiet() && $urandom_range(99) < 38)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		sample_index <= idx;
		sample_value <= val;
		out_x        <= ox;
		out_y        <= oy;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		n_sent++;
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(511)) - 256);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic put_sample(input int unsigned idx, input logic [23:0] val);
		field_mem[idx % fu_pkg::STORE_DEPTH] = val;
		field_set[idx % fu_pkg::STORE_DEPTH] = 1'b1;
		offer(fu_pkg::OP_WRITE, 14'(idx), val, 12'($urandom), 12'($urandom));
	endtask

	// Issues a query; any store entry it would read that has not been written yet
	// is written first, so no query ever reads an undefined entry.
	task automatic ask_pixel(input int unsigned ox, input int unsigned oy, input bit has_exp,
			input int exp_pix, input logic [1:0] exp_st);
		logic [1:0] st;
		int unsigned bx, by, n, ad;
		longint fx, fy;
		pixel_res_t res;
		locate(ox, oy, st, bx, by, fx, fy);
		n = mode_cubic ? 3 : 2;
		if (st == fu_pkg::ST_OK)
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					ad = (bx + j + (by + i) * src_w) % fu_pkg::STORE_DEPTH;
					if (!field_set[ad])
						put_sample(ad, pick_sample());
				end
		res = interpolate(ox, oy);
		if (has_exp) begin
			res.pix = exp_pix;
			res.st  = exp_st;
		end
		pending_pixels = {pending_pixels, res};
		offer(fu_pkg::OP_QUERY, 14'($urandom), 24'($urandom), 12'(ox), 12'(oy));
	endtask

	// Registers are only written once the block has drained and had time to finish
	// any write transfer still inside it.
	task automatic set_reg(input cfg_reg_t r, input int unsigned data);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= r;
		cfg_data     <= 13'(data);
		@(negedge clk);
		cfg_write_en <= 1'b0;
		case (r)
			REG_SRC_W: src_w = data & 8'hFF;
			REG_SRC_H: src_h = data & 8'hFF;
			REG_DST_W: dst_w = data & 13'h1FFF;
			REG_DST_H: dst_h = data & 13'h1FFF;
			default:   mode_cubic = data & 1;
		endcase
	endtask

	// Directed table: extremes of samples and coordinates, both modes, the error
	// statuses, an oversized source whose addresses wrap, and queries beyond the target.
	dir_row_t dir_rows [] = '{
		'{ROW_WR,  0,         24'h7FFFFF, 0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_WR,  1,        -8388608,    0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_WR,  128,       0,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_WR,  129,       0,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          0,    0,    1, 8388607,  fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          1,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          2,    3,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          4095, 4095, 0, 0,        fu_pkg::ST_OK},
		'{ROW_WR,  16383,     24'h123456, 0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_SRC_W, 1,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          5,    5,    1, 0,        fu_pkg::ST_SMALL},
		'{ROW_CFG, REG_SRC_W, 128,        0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_DST_W, 100,        0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          0,    0,    1, 0,        fu_pkg::ST_ZERO},
		'{ROW_CFG, REG_DST_W, 8191,       0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_MODE,  1,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_SRC_H, 3,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          4095, 4095, 0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_SRC_H, 2,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          7,    7,    1, 0,        fu_pkg::ST_SMALL},
		'{ROW_CFG, REG_SRC_W, 255,        0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_SRC_H, 255,        0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_DST_H, 8191,       0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          4095, 2100, 0, 0,        fu_pkg::ST_OK},
		'{ROW_CFG, REG_DST_H, 0,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          3,    3,    1, 0,        fu_pkg::ST_ZERO},
		'{ROW_CFG, REG_SRC_W, 0,          0,    0,    0, 0,        fu_pkg::ST_OK},
		'{ROW_QY,  0,         0,          3,    3,    1, 0,        fu_pkg::ST_SMALL}
	};

	// Main stimulus: reset, directed table, then random phases with fresh settings.
	initial begin
		int unsigned sw, sh, ox, oy;
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = REG_SRC_W;
		cfg_data     = '0;
		in_valid     = 1'b0;
		opcode       = fu_pkg::OP_WRITE;
		sample_index = '0;
		sample_value = '0;
		out_x        = '0;
		out_y        = '0;
		n_errors     = 0;
		n_sent       = 0;
		src_w        = 128;
		src_h        = 128;
		dst_w        = 512;
		dst_h        = 512;
		mode_cubic   = 0;
		for (int k = 0; k < fu_pkg::STORE_DEPTH; k++)
			field_set[k] = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[k]) begin
			case (dir_rows[k].kind)
				ROW_WR:  put_sample(dir_rows[k].idx, 24'(dir_rows[k].val));
				ROW_QY:  ask_pixel(dir_rows[k].ox, dir_rows[k].oy, dir_rows[k].has_exp,
						dir_rows[k].exp_pix, dir_rows[k].exp_st);
				default: set_reg(cfg_reg_t'(dir_rows[k].idx), dir_rows[k].val);
			endcase
		end

		// Random phases: mostly small sources so that each phase fills its field
		// quickly, now and then a large or degenerate one.
		while (n_sent < N_ITEMS) begin
			case ($urandom_range(9))
				0: begin sw = $urandom_range(255); sh = $urandom_range(3, 1); end
				1: begin sw = $urandom_range(3, 1); sh = $urandom_range(255); end
				default: begin sw = $urandom_range(12, 2); sh = $urandom_range(12, 2); end
			endcase
			set_reg(REG_SRC_W, sw);
			set_reg(REG_SRC_H, sh);
			set_reg(REG_DST_W, ($urandom_range(9) == 0) ? $urandom_range(8191)
				: sw * $urandom_range(40, 1) + $urandom_range(3));
			set_reg(REG_DST_H, ($urandom_range(9) == 0) ? $urandom_range(8191)
				: sh * $urandom_range(40, 1) + $urandom_range(3));
			set_reg(REG_MODE, $urandom_range(1));
			repeat ($urandom_range(60, 20)) begin
				if ($urandom_range(3) == 0) begin
					// Writes land inside the field mostly, anywhere in the store sometimes.
					if ($urandom_range(4) == 0 || sw * sh == 0)
						put_sample($urandom_range(fu_pkg::STORE_DEPTH - 1), pick_sample());
					else
						put_sample($urandom_range(sw * sh - 1) % fu_pkg::STORE_DEPTH,
							pick_sample());
				end else begin
					ox = ($urandom_range(7) == 0) ? $urandom_range(4095)
						: $urandom_range((dst_w > 0 && dst_w <= 4096) ? dst_w - 1 : 4095);
					oy = ($urandom_range(7) == 0) ? $urandom_range(4095)
						: $urandom_range((dst_h > 0 && dst_h <= 4096) ? dst_h - 1 : 4095);
					ask_pixel(ox, oy, 0, 0, fu_pkg::ST_OK);
				end
			end
		end
		in_valid <= 1'b0;

		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------
	// Random stalls, plus one long hold-off, started while the sender is offering, so
	// the block backs up into its input.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && cyc >= 8000 && in_valid) begin
				hold_left = 600;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet() && $urandom_range(99) < 38;
			end
		end
	end

	// Each result transfer is checked against the oldest outstanding expectation.
	always @(posedge clk) begin
		pixel_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result pixel %0d status %0d", $realtime,
					pixel_value, status);
				n_errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_value !== want.pix) begin
					$display("%0t: pixel expected %0d actual %0d", $realtime, want.pix,
						pixel_value);
					n_errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $realtime, want.st,
						status);
					n_errors++;
				end
			end
		end
	end

endmodule
